// File: rtl/lpd_pkg.sv
// shared types and constants for the length prefix deframer
package lpd_pkg;

  localparam int unsigned MaxPayloadW   = 15;
  localparam int unsigned LenW          = 16;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned FifoDepth     = 4;
  localparam int unsigned FifoAw        = $clog2(FifoDepth);

  localparam logic [MaxPayloadW-1:0] MaxPayloadReset = MaxPayloadW'(1024);
  localparam logic [MaxPayloadW-1:0] HeaderBytes     = MaxPayloadW'(2);

  typedef enum logic [1:0] {
    PH_LEN_LO  = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HALTED  = 2'd3
  } phase_t;

  typedef struct packed {
    logic             payload_last;
    logic             payload_error;
    logic [ByteW-1:0] payload_data;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

// File: rtl/lpd_core.sv
// input register, framing state machine and header check
module lpd_core import lpd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ByteW-1:0]       data_byte,
  input  logic                   abort,
  input  logic [MaxPayloadW-1:0] max_payload,
  input  logic [FifoAw:0]        fifo_count,
  output push_t                  push
);

  logic                   s1_valid;
  logic [ByteW-1:0]       s1_byte;
  logic                   s1_abort;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [ByteW-1:0]       length_low;
  logic [ByteW-1:0]       length_low_next;
  logic [MaxPayloadW-1:0] bytes_remaining;
  logic [MaxPayloadW-1:0] bytes_remaining_next;

  logic [LenW-1:0]        raw_len;
  logic [MaxPayloadW-1:0] len_mag;
  logic [LenW-1:0]        limit;
  logic                   len_ok;
  logic [MaxPayloadW-1:0] rem;

  // credit: every beat held here or queued needs a free slot downstream
  assign in_ready = (fifo_count + {{FifoAw{1'b0}}, s1_valid}) < (FifoAw+1)'(FifoDepth);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && in_ready;
    end
    if (in_valid && in_ready) begin
      s1_byte  <= data_byte;
      s1_abort <= abort;
    end
  end

  assign raw_len = {s1_byte, length_low};
  assign len_mag = raw_len[MaxPayloadW-1:0];
  assign limit   = {1'b0, max_payload} + {1'b0, HeaderBytes};
  assign len_ok  = !raw_len[LenW-1] && (len_mag > HeaderBytes) &&
                   ({1'b0, len_mag} <= limit);
  assign rem     = (bytes_remaining == '0) ? '0 : bytes_remaining - MaxPayloadW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEN_LO;
      length_low      <= '0;
      bytes_remaining <= '0;
    end else begin
      phase           <= phase_next;
      length_low      <= length_low_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    length_low_next      = length_low;
    bytes_remaining_next = bytes_remaining;
    push                 = '0;
    if (s1_valid) begin
      if (s1_abort) begin
        phase_next           = PH_LEN_LO;
        length_low_next      = '0;
        bytes_remaining_next = '0;
      end else begin
        case (phase)
          PH_LEN_LO: begin
            length_low_next = s1_byte;
            phase_next      = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            if (len_ok) begin
              bytes_remaining_next = len_mag - HeaderBytes;
              phase_next           = PH_PAYLOAD;
            end else begin
              phase_next             = PH_HALTED;
              push.valid             = 1'b1;
              push.res.payload_error = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            bytes_remaining_next  = rem;
            push.valid            = 1'b1;
            push.res.payload_data = s1_byte;
            push.res.payload_last = (rem == '0);
            if (rem == '0) begin
              phase_next      = PH_LEN_LO;
              length_low_next = '0;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/lpd_out_fifo.sv
// small result queue that decouples the core from the output handshake
module lpd_out_fifo import lpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  push_t             push,
  output logic [FifoAw:0]   count,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           head
);

  result_t           mem [FifoDepth];
  logic [FifoAw-1:0] wr_ptr;
  logic [FifoAw-1:0] rd_ptr;
  logic              pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + FifoAw'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FifoAw'(1);
      end
      count <= count + {{FifoAw{1'b0}}, push.valid} - {{FifoAw{1'b0}}, pop};
    end
  end

endmodule

// File: rtl/length_prefix_deframer_top.sv
// length prefix deframer: one byte per beat in, payload bytes and length errors out
// path: a result passes the input register and then the result queue
// throughput: one byte per cycle, held only by the four-entry result queue
// reset: framing returns to the length low byte, max_payload to 1024
// abort in any phase clears framing without a result
module length_prefix_deframer_top import lpd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MaxPayloadW-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ByteW-1:0]       data_byte,
  input  logic                   abort,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ByteW-1:0]       payload_byte,
  output logic                   last,
  output logic                   error
);

  logic [MaxPayloadW-1:0] max_payload;
  logic [FifoAw:0]        fifo_count;
  push_t                  push;
  result_t                head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MaxPayloadReset;
    end else if (cfg_valid && cfg_ready) begin
      max_payload <= cfg_data;
    end
  end

  lpd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .abort       (abort),
    .max_payload (max_payload),
    .fifo_count  (fifo_count),
    .push        (push)
  );

  lpd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .count     (fifo_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign payload_byte = head.payload_data;
  assign last         = head.payload_last;
  assign error        = head.payload_error;

endmodule
